[src/thrl_pkg.sv]
// Shared types, constants and codes for the pose history ring lookup.
`default_nettype none
package thrl_pkg;

    // Ring geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int DELTA_W = 20;
    localparam int ACC_W   = 21;
    localparam int LOC_W   = 32;
    localparam int ANG_W   = 16;
    localparam int LCNT_W  = 5;
    localparam int CFG_W   = 20;
    localparam int CFG_A_W = 2;

    // Register reset values
    localparam logic [DELTA_W-1:0] INTERVAL_RST = DELTA_W'(33000);
    localparam logic [LCNT_W-1:0]  LCNT_RST     = LCNT_W'(11);

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_INTERVAL  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_ENTRIES   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_AUTHORITY = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_RECORD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FETCH,
        ST_REPLY
    } state_t;

    // One stored pose
    typedef struct packed {
        logic signed [LOC_W-1:0] x;
        logic signed [LOC_W-1:0] y;
        logic signed [LOC_W-1:0] z;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] roll;
    } pose_t;

    // Sequencer to compare unit
    typedef struct packed {
        logic             init;
        logic             cmp_en;
        logic [IDX_W-1:0] cmp_idx;
    } scan_ctl_t;

endpackage
`default_nettype wire

[src/thrl_store.sv]
// Ring storage: time and pose memories with per-entry valid bits.
`default_nettype none
module thrl_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clr,
    input  wire logic                          wr_en,
    input  wire logic [thrl_pkg::IDX_W-1:0]    wr_idx,
    input  wire logic [thrl_pkg::TIME_W-1:0]   wr_time,
    input  wire thrl_pkg::pose_t               wr_pose,
    input  wire logic [thrl_pkg::IDX_W-1:0]    time_rd_idx,
    output logic      [thrl_pkg::TIME_W-1:0]   time_rd,
    input  wire logic [thrl_pkg::IDX_W-1:0]    pose_rd_idx,
    output thrl_pkg::pose_t                    pose_rd
);

    logic [thrl_pkg::TIME_W-1:0] time_mem [thrl_pkg::MAX_ENTRIES];
    thrl_pkg::pose_t             pose_mem [thrl_pkg::MAX_ENTRIES];

    logic [thrl_pkg::MAX_ENTRIES-1:0] valid_reg;
    logic [thrl_pkg::MAX_ENTRIES-1:0] valid_next;
    logic [thrl_pkg::TIME_W-1:0]      time_rd_reg;
    logic                             time_vld_reg;
    thrl_pkg::pose_t                  pose_rd_reg;
    logic                             pose_vld_reg;

    // Valid bits: clear empties the whole ring at once
    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Time memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_idx] <= wr_time;
        end
        time_rd_reg  <= time_mem[time_rd_idx];
        time_vld_reg <= valid_reg[time_rd_idx];
    end

    // Pose memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pose_mem[wr_idx] <= wr_pose;
        end
        pose_rd_reg  <= pose_mem[pose_rd_idx];
        pose_vld_reg <= valid_reg[pose_rd_idx];
    end

    // Unwritten entries read as zero
    assign time_rd = time_vld_reg ? time_rd_reg : '0;
    assign pose_rd = pose_vld_reg ? pose_rd_reg : '0;

endmodule
`default_nettype wire

[src/thrl_scan.sv]
// Shared subtract-compare unit tracking the nearest stored time.
`default_nettype none
module thrl_scan (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire thrl_pkg::scan_ctl_t         ctl,
    input  wire logic [thrl_pkg::TIME_W-1:0] entry_time,
    input  wire logic [thrl_pkg::TIME_W-1:0] query_time,
    output logic                             have,
    output logic      [thrl_pkg::IDX_W-1:0]  best_idx
);

    logic                          have_reg;
    logic                          have_next;
    logic [thrl_pkg::IDX_W-1:0]    best_idx_reg;
    logic [thrl_pkg::IDX_W-1:0]    best_idx_next;
    logic [thrl_pkg::TIME_W-1:0]   best_d_reg;
    logic [thrl_pkg::TIME_W-1:0]   best_d_next;
    logic [thrl_pkg::TIME_W:0]     diff_tq;
    logic [thrl_pkg::TIME_W-1:0]   diff_qt;
    logic [thrl_pkg::TIME_W-1:0]   abs_dist;
    logic                          take;

    // Absolute distance: both differences in parallel, borrow selects
    assign diff_tq  = {1'b0, entry_time} - {1'b0, query_time};
    assign diff_qt  = query_time - entry_time;
    assign abs_dist = diff_tq[thrl_pkg::TIME_W] ? diff_qt : diff_tq[thrl_pkg::TIME_W-1:0];

    // Empty entries skipped; strictly smaller wins so ties keep lowest index
    assign take = ctl.cmp_en && (entry_time != '0) &&
                  (!have_reg || (abs_dist < best_d_reg));

    always_comb
    begin
        have_next     = have_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        if (ctl.init)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next     = 1'b1;
            best_idx_next = ctl.cmp_idx;
            best_d_next   = abs_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
    end

    assign have     = have_reg;
    assign best_idx = best_idx_reg;

endmodule
`default_nettype wire

[src/thrl_seq.sv]
// Query sequencer: walks the ring one entry a cycle, then fetches the winner.
`default_nettype none
module thrl_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go_query,
    input  wire logic [thrl_pkg::LEN_W-1:0] ring_len,
    output logic                            busy,
    output logic                            reply,
    output logic      [thrl_pkg::IDX_W-1:0] rd_idx,
    output thrl_pkg::scan_ctl_t             ctl
);

    thrl_pkg::state_t              state_reg;
    thrl_pkg::state_t              state_next;
    logic [thrl_pkg::IDX_W-1:0]    idx_reg;
    logic [thrl_pkg::IDX_W-1:0]    idx_next;
    logic                          cmp_en_reg;
    logic [thrl_pkg::IDX_W-1:0]    cmp_idx_reg;
    logic [thrl_pkg::IDX_W-1:0]    last_idx;
    logic [thrl_pkg::LEN_W-1:0]    len_m1;
    logic                          issue;

    assign len_m1   = ring_len - thrl_pkg::LEN_W'(1);
    assign last_idx = len_m1[thrl_pkg::IDX_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            thrl_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (go_query)
                begin
                    state_next = thrl_pkg::ST_SCAN;
                end
            end
            thrl_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + thrl_pkg::IDX_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = thrl_pkg::ST_LAST;
                end
            end
            thrl_pkg::ST_LAST:  state_next = thrl_pkg::ST_FETCH;
            thrl_pkg::ST_FETCH: state_next = thrl_pkg::ST_REPLY;
            thrl_pkg::ST_REPLY: state_next = thrl_pkg::ST_IDLE;
            default:            state_next = thrl_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        busy  = 1'b1;
        reply = 1'b0;
        issue = 1'b0;
        unique case (state_reg)
            thrl_pkg::ST_IDLE:  busy  = 1'b0;
            thrl_pkg::ST_SCAN:  issue = 1'b1;
            thrl_pkg::ST_LAST:  issue = 1'b0;
            thrl_pkg::ST_FETCH: issue = 1'b0;
            thrl_pkg::ST_REPLY: reply = 1'b1;
            default:            busy  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= thrl_pkg::ST_IDLE;
            idx_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cmp_en_reg <= issue;
        end
    end

    // Read data returns in the cycle after issue; the compare tag is registered alongside it
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= idx_reg;
    end

    assign rd_idx      = idx_reg;
    assign ctl.init    = go_query;
    assign ctl.cmp_en  = cmp_en_reg;
    assign ctl.cmp_idx = cmp_idx_reg;

endmodule
`default_nettype wire

[src/timestamped_history_ring_lookup_core.sv]
// Top level: command decode, record path, configuration and result registers.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------------------------
//  command   | start / busy        | command, delta_time, now_time, pos_*, ang_*, query_time
//  result    | done (1-cycle)      | found, recorded, hit_x/y/z, hit_pitch/yaw/roll
//  config    | cfg_we              | cfg_addr, cfg_wdata
//
// Tick, clear and record-now finish at the accepting edge; done strobes the next cycle.
// Query: busy through SCAN, LAST, FETCH and REPLY, and done is registered from REPLY;
// one entry a cycle in SCAN through the single time read port and subtract-compare unit.
// Reset clears the valid bits at once, so there is no clearing pass.
// The receiver cannot stall: done strobes for one cycle only; result fields hold until the next result.
`default_nettype none
module timestamped_history_ring_lookup_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        command,
    input  wire logic [thrl_pkg::DELTA_W-1:0]      delta_time,
    input  wire logic [thrl_pkg::TIME_W-1:0]       now_time,
    input  wire logic signed [thrl_pkg::LOC_W-1:0] pos_x,
    input  wire logic signed [thrl_pkg::LOC_W-1:0] pos_y,
    input  wire logic signed [thrl_pkg::LOC_W-1:0] pos_z,
    input  wire logic signed [thrl_pkg::ANG_W-1:0] ang_pitch,
    input  wire logic signed [thrl_pkg::ANG_W-1:0] ang_yaw,
    input  wire logic signed [thrl_pkg::ANG_W-1:0] ang_roll,
    input  wire logic [thrl_pkg::TIME_W-1:0]       query_time,
    output logic                                   done,
    output logic                                   found,
    output logic                                   recorded,
    output logic signed [thrl_pkg::LOC_W-1:0]      hit_x,
    output logic signed [thrl_pkg::LOC_W-1:0]      hit_y,
    output logic signed [thrl_pkg::LOC_W-1:0]      hit_z,
    output logic signed [thrl_pkg::ANG_W-1:0]      hit_pitch,
    output logic signed [thrl_pkg::ANG_W-1:0]      hit_yaw,
    output logic signed [thrl_pkg::ANG_W-1:0]      hit_roll,
    input  wire logic                              cfg_we,
    input  wire logic [thrl_pkg::CFG_A_W-1:0]      cfg_addr,
    input  wire logic [thrl_pkg::CFG_W-1:0]        cfg_wdata
);

    // Configuration registers
    logic [thrl_pkg::DELTA_W-1:0] interval_reg;
    logic [thrl_pkg::LCNT_W-1:0]  entries_reg;
    logic                         authority_reg;

    // Ring control state
    logic [thrl_pkg::IDX_W-1:0]   ptr_reg;
    logic [thrl_pkg::IDX_W-1:0]   ptr_next;
    logic [thrl_pkg::ACC_W-1:0]   acc_reg;
    logic [thrl_pkg::ACC_W-1:0]   acc_next;
    logic [thrl_pkg::TIME_W-1:0]  query_reg;

    // Result registers
    logic                         done_reg;
    logic                         done_next;
    logic                         found_reg;
    logic                         found_next;
    logic                         recorded_reg;
    logic                         recorded_next;
    thrl_pkg::pose_t              hit_reg;
    thrl_pkg::pose_t              hit_next;

    logic                         accept;
    thrl_pkg::cmd_t               cmd;
    logic [thrl_pkg::LEN_W-1:0]   ring_len;
    logic [thrl_pkg::ACC_W:0]     acc_sum;
    logic [thrl_pkg::ACC_W-1:0]   acc_sat;
    logic                         tick_due;
    logic                         wr_en;
    logic                         clr;
    logic                         go_query;
    logic [thrl_pkg::IDX_W-1:0]   wr_idx;
    logic [thrl_pkg::LEN_W:0]     wr_idx_p1;
    thrl_pkg::pose_t              wr_pose;
    logic                         reply;
    logic [thrl_pkg::IDX_W-1:0]   rd_idx;
    thrl_pkg::scan_ctl_t          scan_ctl;
    logic [thrl_pkg::TIME_W-1:0]  time_rd;
    thrl_pkg::pose_t              pose_rd;
    logic                         have;
    logic [thrl_pkg::IDX_W-1:0]   best_idx;

    assign accept   = start && !busy;
    assign cmd      = thrl_pkg::cmd_t'(command);
    assign go_query = accept && (cmd == thrl_pkg::CMD_QUERY);
    assign clr      = accept && (cmd == thrl_pkg::CMD_CLEAR);

    // Ring length, clamped to 1..MAX_ENTRIES
    always_comb
    begin
        priority if (entries_reg == '0)
        begin
            ring_len = thrl_pkg::LEN_W'(1);
        end
        else if (32'(entries_reg) > 32'(thrl_pkg::MAX_ENTRIES))
        begin
            ring_len = thrl_pkg::LEN_W'(thrl_pkg::MAX_ENTRIES);
        end
        else
        begin
            ring_len = thrl_pkg::LEN_W'(entries_reg);
        end
    end

    // Tick accumulator, saturating
    assign acc_sum  = {1'b0, acc_reg} + (thrl_pkg::ACC_W + 1)'(delta_time);
    assign acc_sat  = acc_sum[thrl_pkg::ACC_W] ? '1 : acc_sum[thrl_pkg::ACC_W-1:0];
    assign tick_due = acc_sat >= thrl_pkg::ACC_W'(interval_reg);

    assign wr_en = accept && ((cmd == thrl_pkg::CMD_RECORD) ||
                   ((cmd == thrl_pkg::CMD_TICK) && authority_reg && tick_due));

    // Write slot: a pointer past the ring restarts at entry zero
    assign wr_idx    = ((thrl_pkg::LEN_W)'(ptr_reg) >= ring_len) ? '0 : ptr_reg;
    assign wr_idx_p1 = (thrl_pkg::LEN_W + 1)'(wr_idx) + (thrl_pkg::LEN_W + 1)'(1);

    assign wr_pose.x     = pos_x;
    assign wr_pose.y     = pos_y;
    assign wr_pose.z     = pos_z;
    assign wr_pose.pitch = ang_pitch;
    assign wr_pose.yaw   = ang_yaw;
    assign wr_pose.roll  = ang_roll;

    // Pointer and accumulator update
    always_comb
    begin
        ptr_next = ptr_reg;
        acc_next = acc_reg;
        if (clr)
        begin
            ptr_next = '0;
            acc_next = '0;
        end
        else
        begin
            if (wr_en)
            begin
                ptr_next = (wr_idx_p1 == (thrl_pkg::LEN_W + 1)'(ring_len)) ? '0 :
                           wr_idx_p1[thrl_pkg::IDX_W-1:0];
            end
            if (accept && (cmd == thrl_pkg::CMD_TICK) && authority_reg)
            begin
                acc_next = tick_due ? '0 : acc_sat;
            end
        end
    end

    // Result register load
    always_comb
    begin
        done_next     = 1'b0;
        found_next    = found_reg;
        recorded_next = recorded_reg;
        hit_next      = hit_reg;
        if (accept && (cmd != thrl_pkg::CMD_QUERY))
        begin
            done_next     = 1'b1;
            found_next    = 1'b0;
            recorded_next = wr_en;
            hit_next      = '0;
        end
        else if (reply)
        begin
            done_next     = 1'b1;
            found_next    = have;
            recorded_next = 1'b0;
            hit_next      = have ? pose_rd : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= thrl_pkg::INTERVAL_RST;
            entries_reg   <= thrl_pkg::LCNT_RST;
            authority_reg <= 1'b1;
            ptr_reg       <= '0;
            acc_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            // Configuration writes; unknown indexes are dropped
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    thrl_pkg::REG_INTERVAL:  interval_reg  <= cfg_wdata;
                    thrl_pkg::REG_ENTRIES:   entries_reg   <= cfg_wdata[thrl_pkg::LCNT_W-1:0];
                    thrl_pkg::REG_AUTHORITY: authority_reg <= cfg_wdata[0];
                    default:                 authority_reg <= authority_reg;
                endcase
            end
            ptr_reg  <= ptr_next;
            acc_reg  <= acc_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_query)
        begin
            query_reg <= query_time;
        end
        found_reg    <= found_next;
        recorded_reg <= recorded_next;
        hit_reg      <= hit_next;
    end

    thrl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .go_query (go_query),
        .ring_len (ring_len),
        .busy     (busy),
        .reply    (reply),
        .rd_idx   (rd_idx),
        .ctl      (scan_ctl)
    );

    thrl_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .clr         (clr),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_time     (now_time),
        .wr_pose     (wr_pose),
        .time_rd_idx (rd_idx),
        .time_rd     (time_rd),
        .pose_rd_idx (best_idx),
        .pose_rd     (pose_rd)
    );

    thrl_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .entry_time (time_rd),
        .query_time (query_reg),
        .have       (have),
        .best_idx   (best_idx)
    );

    assign done      = done_reg;
    assign found     = found_reg;
    assign recorded  = recorded_reg;
    assign hit_x     = hit_reg.x;
    assign hit_y     = hit_reg.y;
    assign hit_z     = hit_reg.z;
    assign hit_pitch = hit_reg.pitch;
    assign hit_yaw   = hit_reg.yaw;
    assign hit_roll  = hit_reg.roll;

endmodule
`default_nettype wire

[src/thrl_checker.sv]
// Port-level checks for the history ring lookup, bound to the top level.
`default_nettype none
module thrl_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [1:0]                        command,
    input wire logic                              done,
    input wire logic                              found,
    input wire logic                              recorded,
    input wire logic signed [thrl_pkg::LOC_W-1:0] hit_x,
    input wire logic signed [thrl_pkg::LOC_W-1:0] hit_y,
    input wire logic signed [thrl_pkg::LOC_W-1:0] hit_z,
    input wire logic signed [thrl_pkg::ANG_W-1:0] hit_pitch,
    input wire logic signed [thrl_pkg::ANG_W-1:0] hit_yaw,
    input wire logic signed [thrl_pkg::ANG_W-1:0] hit_roll
);

    // A result never shows while a query is still scanning
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Non-query transactions answer on the next cycle
    a_quick_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != thrl_pkg::CMD_QUERY)) |=> (done && !busy))
        else $error("non-query transaction did not answer next cycle");

    // A query holds the block busy and gives no result right away
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == thrl_pkg::CMD_QUERY)) |=> (busy && !done))
        else $error("query did not start its scan");

    // A miss or a non-query result carries zero pose
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> ((hit_x == '0) && (hit_y == '0) && (hit_z == '0) &&
                              (hit_pitch == '0) && (hit_yaw == '0) && (hit_roll == '0)))
        else $error("nonzero pose without a hit");

    // A hit comes only from a query, which never records
    a_hit_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> !recorded)
        else $error("hit and record in one result");

endmodule

bind timestamped_history_ring_lookup_core thrl_checker u_thrl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .found     (found),
    .recorded  (recorded),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_z     (hit_z),
    .hit_pitch (hit_pitch),
    .hit_yaw   (hit_yaw),
    .hit_roll  (hit_roll)
);
`default_nettype wire

[verif/tb_top.sv]
// Testbench for the pose history ring: directed and random commands, checked by a local model.
module tb_top;
    import thrl_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;
    localparam int PHASE_ITEMS  = 100;
    localparam logic [CFG_A_W-1:0] REG_SPARE = 2'd3;
    localparam logic [ACC_W:0]     ACC_CAP   = (ACC_W + 1)'((1 << ACC_W) - 1);

    // One command transaction, plus the pacing the driver applies before it
    typedef struct {
        cmd_t                    op;
        logic [DELTA_W-1:0]      dt;
        logic [TIME_W-1:0]       now;
        logic signed [LOC_W-1:0] x;
        logic signed [LOC_W-1:0] y;
        logic signed [LOC_W-1:0] z;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] roll;
        logic [TIME_W-1:0]       qt;
        int                      gap;
        bit                      hold;
    } pose_cmd_t;

    typedef struct {
        logic  found;
        logic  recorded;
        pose_t pose;
    } pose_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] command = CMD_TICK;
    logic [DELTA_W-1:0] delta_time = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic signed [LOC_W-1:0] pos_x = '0;
    logic signed [LOC_W-1:0] pos_y = '0;
    logic signed [LOC_W-1:0] pos_z = '0;
    logic signed [ANG_W-1:0] ang_pitch = '0;
    logic signed [ANG_W-1:0] ang_yaw = '0;
    logic signed [ANG_W-1:0] ang_roll = '0;
    logic [TIME_W-1:0] query_time = '0;
    logic cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = REG_INTERVAL;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic busy;
    logic done;
    logic found;
    logic recorded;
    logic signed [LOC_W-1:0] hit_x;
    logic signed [LOC_W-1:0] hit_y;
    logic signed [LOC_W-1:0] hit_z;
    logic signed [ANG_W-1:0] hit_pitch;
    logic signed [ANG_W-1:0] hit_yaw;
    logic signed [ANG_W-1:0] hit_roll;

    // Stimulus side
    pose_cmd_t cmd_q[$];
    pose_cmd_t nxt;
    bit have_next;
    bit presenting;
    int gap_left;
    int sent_cnt;
    logic [DELTA_W-1:0] stim_iv = INTERVAL_RST;
    logic [TIME_W-1:0] stim_now = 32'd1_000_000;

    // Model of the ring, kept by the monitor
    logic [TIME_W-1:0] hist_time[MAX_ENTRIES];
    pose_t hist_pose[MAX_ENTRIES];
    int unsigned hist_wp;
    logic [ACC_W-1:0] since_rec;
    logic [DELTA_W-1:0] reg_iv;
    logic [LCNT_W-1:0] reg_len;
    logic reg_auth;
    pose_reply_t reply_q[$];

    // Checking and statistics
    int res_cnt;
    int errors = 0;
    int stall_cycles;
    int n_cmds = 0;
    int n_records = 0;
    int n_queries = 0;
    int n_hits = 0;
    int n_clears = 0;
    int n_cfg = 0;

    timestamped_history_ring_lookup_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .delta_time (delta_time),
        .now_time   (now_time),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .ang_pitch  (ang_pitch),
        .ang_yaw    (ang_yaw),
        .ang_roll   (ang_roll),
        .query_time (query_time),
        .done       (done),
        .found      (found),
        .recorded   (recorded),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z),
        .hit_pitch  (hit_pitch),
        .hit_yaw    (hit_yaw),
        .hit_roll   (hit_roll),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned ring_len();
        if (reg_len == 0)
            return 1;
        if (reg_len > MAX_ENTRIES)
            return MAX_ENTRIES;
        return reg_len;
    endfunction

    // Write at the pointer; a pointer left beyond a shortened ring restarts at entry 0
    function automatic void store_pose(pose_cmd_t c);
        int unsigned n;
        int unsigned p;
        n = ring_len();
        p = (hist_wp >= n) ? 0 : hist_wp;
        hist_time[p] = c.now;
        hist_pose[p] = '{x: c.x, y: c.y, z: c.z, pitch: c.pitch, yaw: c.yaw, roll: c.roll};
        hist_wp = (p + 1) % n;
    endfunction

    function automatic pose_reply_t ring_step(pose_cmd_t c);
        pose_reply_t y;
        logic [ACC_W:0] sum;
        logic [TIME_W-1:0] d;
        logic [TIME_W-1:0] best_d;
        int unsigned best;
        bit have;
        y = '{found: 1'b0, recorded: 1'b0, pose: '0};
        best_d = '0;
        best = 0;
        have = 1'b0;
        case (c.op)
            CMD_TICK:
            begin
                if (reg_auth)
                begin
                    sum = since_rec + c.dt;
                    if (sum > ACC_CAP)
                        sum = ACC_CAP;
                    if (sum >= reg_iv)
                    begin
                        store_pose(c);
                        since_rec = '0;
                        y.recorded = 1'b1;
                    end
                    else
                        since_rec = sum[ACC_W-1:0];
                end
            end
            CMD_QUERY:
            begin
                // zero time marks an empty entry; strict compare keeps the lowest index on ties
                for (int i = 0; i < ring_len(); i++)
                begin
                    if (hist_time[i] != 0)
                    begin
                        d = (hist_time[i] >= c.qt) ? hist_time[i] - c.qt : c.qt - hist_time[i];
                        if (!have || d < best_d)
                        begin
                            have = 1'b1;
                            best_d = d;
                            best = i;
                        end
                    end
                end
                if (have)
                begin
                    y.found = 1'b1;
                    y.pose = hist_pose[best];
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    hist_time[i] = '0;
                    hist_pose[i] = '0;
                end
                hist_wp = 0;
                since_rec = '0;
            end
            default:
            begin
                store_pose(c);
                y.recorded = 1'b1;
            end
        endcase
        return y;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [31:0] pick_word(int w);
        logic [31:0] neg;
        neg = 32'h1 << (w - 1);
        case ($urandom_range(0, 15))
            0: return neg;
            1: return neg - 1;
            2: return '0;
            3: return (neg << 1) - 1;
            default: return $urandom();
        endcase
    endfunction

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap(bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic pose_cmd_t make_cmd(cmd_t op, logic [DELTA_W-1:0] dt,
                                           logic [TIME_W-1:0] now, logic [TIME_W-1:0] qt);
        pose_cmd_t c;
        c.op = op;
        c.dt = dt;
        c.now = now;
        c.qt = qt;
        c.x = pick_word(LOC_W);
        c.y = pick_word(LOC_W);
        c.z = pick_word(LOC_W);
        c.pitch = ANG_W'(pick_word(ANG_W));
        c.yaw = ANG_W'(pick_word(ANG_W));
        c.roll = ANG_W'(pick_word(ANG_W));
        c.gap = pick_gap(1'b0);
        c.hold = 1'b0;
        return c;
    endfunction

    // Grid mode packs times onto a coarse lattice so queries often tie
    function automatic pose_cmd_t rand_cmd(bit grid, bit burst);
        pose_cmd_t c;
        cmd_t op;
        int unsigned r;
        logic [DELTA_W-1:0] dt;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] qt;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = CMD_TICK;
        else if (r < 70)
            op = CMD_QUERY;
        else if (r < 97)
            op = CMD_RECORD;
        else
            op = CMD_CLEAR;

        r = $urandom_range(0, 9);
        if (r < 7)
            dt = DELTA_W'($urandom_range(0, stim_iv / 3 + 1));
        else if (r < 9)
            dt = DELTA_W'($urandom_range(stim_iv, 20'hFFFFF));
        else
            dt = DELTA_W'($urandom());

        r = $urandom_range(0, 99);
        if (grid)
            now = 32'd100 * $urandom_range(0, 30);
        else if (r < 85)
        begin
            stim_now = stim_now + $urandom_range(1, 40000);
            now = stim_now;
        end
        else if (r < 95)
            now = pick_word(TIME_W);
        else
            now = '0;

        r = $urandom_range(0, 99);
        if (grid)
            qt = 32'd50 * $urandom_range(0, 62);
        else if (r < 50)
            qt = stim_now - $urandom_range(0, 400000);
        else if (r < 65)
            qt = stim_now + $urandom_range(0, 1000);
        else
            qt = pick_word(TIME_W);

        c = make_cmd(op, dt, now, qt);
        c.gap = pick_gap(burst);
        c.hold = ($urandom_range(0, 24) == 0);
        return c;
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_q.size() != 0 || have_next || presenting || sent_cnt != res_cnt);
    endtask

    // Register writes only with nothing in flight; spare bits above the entries and authority registers are random
    task automatic set_regs(logic [DELTA_W-1:0] iv, logic [LCNT_W-1:0] len, logic auth,
                            bit spare);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_addr <= REG_INTERVAL;
        cfg_wdata <= iv;
        @(posedge clk);
        cfg_addr <= REG_ENTRIES;
        cfg_wdata <= {(CFG_W - LCNT_W)'($urandom()), len};
        @(posedge clk);
        cfg_addr <= REG_AUTHORITY;
        cfg_wdata <= {(CFG_W - 1)'($urandom()), auth};
        if (spare)
        begin
            @(posedge clk);
            cfg_addr <= REG_SPARE;
            cfg_wdata <= CFG_W'($urandom());
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        stim_iv = iv;
    endtask

    task automatic run_phase(logic [DELTA_W-1:0] iv, logic [LCNT_W-1:0] len, logic auth,
                             bit grid, bit burst);
        set_regs(iv, len, auth, 1'b0);
        for (int i = 0; i < PHASE_ITEMS; i++)
            cmd_q.push_back(rand_cmd(grid, burst));
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        int owed;
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= CMD_TICK;
            delta_time <= '0;
            now_time <= '0;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            ang_pitch <= '0;
            ang_yaw <= '0;
            ang_roll <= '0;
            query_time <= '0;
            presenting = 1'b0;
            have_next = 1'b0;
            gap_left = 0;
            sent_cnt = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                presenting = 1'b0;
                sent_cnt++;
            end
            if (!presenting)
            begin
                if (!have_next && cmd_q.size() != 0)
                begin
                    nxt = cmd_q.pop_front();
                    have_next = 1'b1;
                    gap_left = nxt.gap;
                end
                // results still owed once this edge settles
                owed = sent_cnt - res_cnt - int'(done);
                if (have_next && gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (have_next && (!nxt.hold || owed <= 0))
                begin
                    command <= nxt.op;
                    delta_time <= nxt.dt;
                    now_time <= nxt.now;
                    pos_x <= nxt.x;
                    pos_y <= nxt.y;
                    pos_z <= nxt.z;
                    ang_pitch <= nxt.pitch;
                    ang_yaw <= nxt.yaw;
                    ang_roll <= nxt.roll;
                    query_time <= nxt.qt;
                    start <= 1'b1;
                    presenting = 1'b1;
                    have_next = 1'b0;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        pose_cmd_t c;
        pose_reply_t y;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                hist_time[i] = '0;
                hist_pose[i] = '0;
            end
            hist_wp = 0;
            since_rec = '0;
            reg_iv = INTERVAL_RST;
            reg_len = LCNT_RST;
            reg_auth = 1'b1;
            res_cnt <= 0;
            stall_cycles = 0;
        end
        else
        begin
            // result transaction against the oldest prediction
            if (done)
            begin
                res_cnt <= res_cnt + 1;
                if (reply_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no command outstanding", $time);
                end
                else
                begin
                    y = reply_q.pop_front();
                    check_field("found", y.found, found);
                    check_field("recorded", y.recorded, recorded);
                    check_field("hit_x", y.pose.x, hit_x);
                    check_field("hit_y", y.pose.y, hit_y);
                    check_field("hit_z", y.pose.z, hit_z);
                    check_field("hit_pitch", y.pose.pitch, hit_pitch);
                    check_field("hit_yaw", y.pose.yaw, hit_yaw);
                    check_field("hit_roll", y.pose.roll, hit_roll);
                end
            end

            // accepted command transaction, rebuilt from the ports
            if (start && !busy)
            begin
                c.op = cmd_t'(command);
                c.dt = delta_time;
                c.now = now_time;
                c.x = pos_x;
                c.y = pos_y;
                c.z = pos_z;
                c.pitch = ang_pitch;
                c.yaw = ang_yaw;
                c.roll = ang_roll;
                c.qt = query_time;
                y = ring_step(c);
                reply_q.push_back(y);
                n_cmds++;
                n_records += y.recorded;
                n_hits += y.found;
                if (c.op == CMD_QUERY)
                    n_queries++;
                if (c.op == CMD_CLEAR)
                    n_clears++;
            end

            if (cfg_we)
            begin
                n_cfg++;
                case (cfg_addr)
                    REG_INTERVAL: reg_iv = cfg_wdata[DELTA_W-1:0];
                    REG_ENTRIES: reg_len = cfg_wdata[LCNT_W-1:0];
                    REG_AUTHORITY: reg_auth = cfg_wdata[0];
                    default: ;
                endcase
            end

            // watchdog on cycles with no transaction either way
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : stimulus
        pose_cmd_t c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty ring, zero-time entry, extremes of every field, ties
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, 32'd5, '0));
        cmd_q.push_back(make_cmd(CMD_RECORD, '0, '0, '0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd12345));
        c = make_cmd(CMD_RECORD, '0, 32'hFFFF_FFFF, '0);
        c.x = 32'sh7FFF_FFFF;
        c.y = 32'sh7FFF_FFFF;
        c.z = 32'sh7FFF_FFFF;
        c.pitch = 16'sh7FFF;
        c.yaw = 16'sh7FFF;
        c.roll = 16'sh7FFF;
        cmd_q.push_back(c);
        c = make_cmd(CMD_RECORD, '0, 32'd1, '0);
        c.x = 32'sh8000_0000;
        c.y = 32'sh8000_0000;
        c.z = 32'sh8000_0000;
        c.pitch = 16'sh8000;
        c.yaw = 16'sh8000;
        c.roll = 16'sh8000;
        cmd_q.push_back(c);
        cmd_q.push_back(make_cmd(CMD_RECORD, '0, 32'd100, '0));
        cmd_q.push_back(make_cmd(CMD_RECORD, '0, 32'd200, '0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd150));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'hFFFF_FFFF));
        // accumulator just below, at and far past the interval
        cmd_q.push_back(make_cmd(CMD_TICK, '0, 32'd4000, '0));
        cmd_q.push_back(make_cmd(CMD_TICK, 20'd32999, 32'd4500, '0));
        cmd_q.push_back(make_cmd(CMD_TICK, 20'd1, 32'd5000, '0));
        cmd_q.push_back(make_cmd(CMD_TICK, 20'hFFFFF, 32'd6000, '0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd5500));

        // authority off, ring shortened under the pointer
        set_regs(20'd0, 5'd3, 1'b0, 1'b1);
        cmd_q.push_back(make_cmd(CMD_TICK, 20'd5, 32'd700, '0));
        cmd_q.push_back(make_cmd(CMD_RECORD, '0, 32'd777, '0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd6000));

        // interval zero, ring length zero acts as one
        set_regs(20'd0, 5'd0, 1'b1, 1'b0);
        cmd_q.push_back(make_cmd(CMD_TICK, '0, 32'd42, '0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd9));

        // oversize ring length, older entries visible again, widest interval
        set_regs(20'hFFFFF, 5'd31, 1'b1, 1'b0);
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd6100));
        cmd_q.push_back(make_cmd(CMD_TICK, 20'hFFFFE, 32'd8000, '0));
        cmd_q.push_back(make_cmd(CMD_TICK, 20'd1, 32'd9000, '0));
        cmd_q.push_back(make_cmd(CMD_CLEAR, '0, '0, '0));
        cmd_q.push_back(make_cmd(CMD_QUERY, '0, '0, 32'd6000));

        // random phases over a spread of settings; the register write forces a full drain
        run_phase(20'd33000, 5'd11, 1'b1, 1'b0, 1'b0);
        run_phase(20'd1, 5'd16, 1'b1, 1'b1, 1'b1);
        run_phase(20'd1000000, 5'd1, 1'b1, 1'b0, 1'b0);
        run_phase(20'd500, 5'd5, 1'b0, 1'b1, 1'b0);
        run_phase(20'hFFFFF, 5'd16, 1'b1, 1'b0, 1'b0);
        run_phase(20'd37, 5'd8, 1'b1, 1'b1, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d commands and %0d register writes: %0d records, %0d clears,",
                 n_cmds, n_cfg, n_records, n_clears);
        $display("%0d lookups of which %0d found a pose", n_queries, n_hits);
        if (errors == 0 && reply_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
